// ----- sv/ffaa_pkg.sv -----
// Shared constants for the first-fit arena allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ffaa_pkg;

    localparam int HDR_BYTES      = 12;
    localparam int RESERVED_BYTES = 4;
    localparam int MIN_ARENA      = 16;
    localparam int ARENA_W        = 17;
    localparam int OFFSET_W       = 16;
    localparam int SIZE_W         = 16;
    localparam int ALIGN_W        = 17;
    localparam int BASE_W         = 18;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_UNUSED   = 2'd3
    } status_t;

    localparam logic [2:0] ADDR_ARENA = 3'd0;

endpackage
`default_nettype wire

// ----- sv/first_fit_arena_allocator.sv -----
// First-fit arena allocator: block list in one synchronous memory, walked per request.
// Depends on ffaa_pkg.
// Free walks the list from the head until a header matches the offset. Allocate scans for a free
// slot, then tries each gap in list order (the tail gap last), with a bitwise remainder step per
// gap when the alignment is above 1, and links the new block behind its predecessor if any.
// Clear, unused kinds and an allocate with a full table are answered straight from idle.
// One item at a time; a new beat is taken once the result beat has left.
// Reset (rst_n, asynchronous): empty list, all slots free, counts zero, arena_bytes ARENA_MAX_BYTES capped at 65536.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_arena_allocator
    import ffaa_pkg::*;
#(
    parameter int MAX_BLOCKS      = 256,
    parameter int ARENA_MAX_BYTES = 65536
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // request_size[15:0], alignment[32:16], free_offset[48:33], zero pad
    input  wire logic [55:0] s_tdata,
    // kind[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // data_offset[15:0], used_blocks[24:16], used_bytes[41:25], zero pad
    output logic      [47:0] m_tdata,
    // status[1:0]
    output logic      [1:0]  m_tuser
);

    localparam int SW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int NW = SW + 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int EW = OFFSET_W + ARENA_W + NW;
    localparam logic [NW-1:0] NULL_SLOT = NW'(MAX_BLOCKS);
    localparam logic [ARENA_W-1:0] ARENA_RESET =
        (ARENA_MAX_BYTES < 65536) ? ARENA_W'(ARENA_MAX_BYTES) : ARENA_W'(65536);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_FETCH, S_EVAL, S_REM, S_CHECK, S_LINK
    } state_t;

    state_t               state_reg;
    logic [ARENA_W-1:0]   arena_reg;
    logic [NW-1:0]        head_reg;
    logic [MAX_BLOCKS-1:0] in_use_reg;
    logic [CW-1:0]        count_reg;
    logic [ARENA_W-1:0]   total_reg;
    kind_t                kind_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [ALIGN_W-1:0]   align_reg;
    logic [OFFSET_W-1:0]  off_reg;
    logic [SW-1:0]        slot_reg;
    logic [NW-1:0]        cur_reg;
    logic [NW-1:0]        prev_reg;
    logic [OFFSET_W-1:0]  prev_hdr_reg;
    logic [ARENA_W-1:0]   prev_len_reg;
    logic [BASE_W-1:0]    base_reg;
    logic [ARENA_W-1:0]   end_reg;
    logic [ALIGN_W-1:0]   rem_reg;
    logic [4:0]           bit_reg;
    logic                 out_valid_reg;
    logic [OFFSET_W-1:0]  out_data_reg;
    status_t              out_status_reg;

    logic [EW-1:0] mem [MAX_BLOCKS];
    logic [EW-1:0] rd_data_reg;
    logic          mem_re;
    logic          mem_we;
    logic [SW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;

    logic [OFFSET_W-1:0] rd_hdr;
    logic [ARENA_W-1:0]  rd_len;
    logic [NW-1:0]       rd_next;
    logic [NW-1:0]       rd_link;
    logic                cur_null;
    logic [BASE_W:0]     rem_try;
    logic [BASE_W:0]     d_val;
    logic [BASE_W+1:0]   d_end;
    logic                fit;
    logic                match;
    logic                cfg_wr;
    logic [ARENA_W-1:0]  cfg_val;
    logic [ALIGN_W-1:0]  in_align;
    logic [BASE_W-1:0]   next_start;

    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_ARENA) ? 32'(arena_reg) : 32'd0;
    assign cfg_wr   = psel && penable && pwrite && (paddr == ADDR_ARENA);
    assign cfg_val  = pwdata[ARENA_W-1:0];

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {6'd0, total_reg, 9'(count_reg), out_data_reg};

    assign in_align = (s_tdata[32:16] == '0) ? ALIGN_W'(1) : s_tdata[32:16];

    assign rd_hdr   = rd_data_reg[EW-1 -: OFFSET_W];
    assign rd_len   = rd_data_reg[NW +: ARENA_W];
    assign rd_next  = rd_data_reg[NW-1:0];
    assign rd_link  = (rd_next < NULL_SLOT) ? rd_next : NULL_SLOT;
    assign cur_null = (cur_reg == NULL_SLOT);
    assign next_start = BASE_W'(rd_hdr) + BASE_W'(rd_len) + BASE_W'(HDR_BYTES);

    assign rem_try  = {1'b0, rem_reg, base_reg[bit_reg]};
    assign d_val    = (rem_reg == '0) ? (BASE_W+1)'(base_reg)
                    : (BASE_W+1)'(base_reg) + (BASE_W+1)'(align_reg) - (BASE_W+1)'(rem_reg);
    assign d_end    = (BASE_W+2)'(d_val) + (BASE_W+2)'(size_reg);
    assign fit      = (d_val <= (BASE_W+1)'(17'hFFFF)) && (d_end <= (BASE_W+2)'(end_reg));
    assign match    = ((ARENA_W)'(rd_hdr) + ARENA_W'(HDR_BYTES)) == ARENA_W'(off_reg);

    assign mem_re   = (state_reg == S_FETCH) && !cur_null;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = slot_reg;
        mem_wdata = {d_val[OFFSET_W-1:0] - OFFSET_W'(HDR_BYTES),
                     ARENA_W'(size_reg) + ARENA_W'(HDR_BYTES), cur_reg};
        unique case (state_reg)
            S_CHECK:
            begin
                mem_we = fit;
            end
            S_LINK:
            begin
                mem_we    = 1'b1;
                mem_waddr = prev_reg[SW-1:0];
                mem_wdata = {prev_hdr_reg, prev_len_reg, NW'(slot_reg)};
            end
            S_EVAL:
            begin
                mem_we    = (kind_reg == KIND_FREE) && match && (prev_reg != NULL_SLOT);
                mem_waddr = prev_reg[SW-1:0];
                mem_wdata = {prev_hdr_reg, prev_len_reg, rd_link};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[cur_reg[SW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            arena_reg      <= ARENA_RESET;
            head_reg       <= NULL_SLOT;
            in_use_reg     <= '0;
            count_reg      <= '0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_data_reg   <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (cfg_val < ARENA_W'(MIN_ARENA))
                begin
                    arena_reg <= ARENA_W'(MIN_ARENA);
                end
                else if (32'(cfg_val) > 32'(ARENA_MAX_BYTES))
                begin
                    arena_reg <= ARENA_W'(ARENA_MAX_BYTES);
                end
                else
                begin
                    arena_reg <= cfg_val;
                end
            end
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        kind_reg     <= kind_t'(s_tuser);
                        size_reg     <= s_tdata[15:0];
                        align_reg    <= in_align;
                        off_reg      <= s_tdata[48:33];
                        slot_reg     <= '0;
                        cur_reg      <= head_reg;
                        prev_reg     <= NULL_SLOT;
                        base_reg     <= BASE_W'(RESERVED_BYTES + HDR_BYTES);
                        out_data_reg <= '0;
                        unique case (kind_t'(s_tuser))
                            KIND_ALLOC:
                            begin
                                if (32'(count_reg) >= 32'(MAX_BLOCKS))
                                begin
                                    out_status_reg <= ST_NO_SPACE;
                                    out_valid_reg  <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            KIND_FREE:
                            begin
                                state_reg <= S_FETCH;
                            end
                            KIND_CLEAR:
                            begin
                                head_reg       <= NULL_SLOT;
                                in_use_reg     <= '0;
                                count_reg      <= '0;
                                total_reg      <= '0;
                                out_status_reg <= ST_OK;
                                out_valid_reg  <= 1'b1;
                            end
                            default:
                            begin
                                out_status_reg <= ST_OK;
                                out_valid_reg  <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (!in_use_reg[slot_reg])
                    begin
                        state_reg <= S_FETCH;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + SW'(1);
                    end
                end
                S_FETCH:
                begin
                    if (cur_null)
                    begin
                        if (kind_reg == KIND_FREE)
                        begin
                            out_status_reg <= ST_NOT_FOUND;
                            out_valid_reg  <= 1'b1;
                            state_reg      <= S_IDLE;
                        end
                        else
                        begin
                            end_reg   <= arena_reg;
                            rem_reg   <= '0;
                            bit_reg   <= 5'(BASE_W - 1);
                            state_reg <= (align_reg == ALIGN_W'(1)) ? S_CHECK : S_REM;
                        end
                    end
                    else
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    if (kind_reg == KIND_FREE)
                    begin
                        if (match)
                        begin
                            if (prev_reg == NULL_SLOT)
                            begin
                                head_reg <= rd_link;
                            end
                            in_use_reg[cur_reg[SW-1:0]] <= 1'b0;
                            count_reg      <= count_reg - CW'(1);
                            total_reg      <= total_reg - (rd_len - ARENA_W'(HDR_BYTES));
                            out_status_reg <= ST_OK;
                            out_valid_reg  <= 1'b1;
                            state_reg      <= S_IDLE;
                        end
                        else
                        begin
                            prev_reg     <= cur_reg;
                            prev_hdr_reg <= rd_hdr;
                            prev_len_reg <= rd_len;
                            cur_reg      <= rd_link;
                            state_reg    <= S_FETCH;
                        end
                    end
                    else
                    begin
                        end_reg   <= ARENA_W'(rd_hdr);
                        rem_reg   <= '0;
                        bit_reg   <= 5'(BASE_W - 1);
                        state_reg <= (align_reg == ALIGN_W'(1)) ? S_CHECK : S_REM;
                    end
                end
                S_REM:
                begin
                    if (rem_try >= (BASE_W+1)'(align_reg))
                    begin
                        rem_reg <= ALIGN_W'(rem_try - (BASE_W+1)'(align_reg));
                    end
                    else
                    begin
                        rem_reg <= ALIGN_W'(rem_try);
                    end
                    if (bit_reg == '0)
                    begin
                        state_reg <= S_CHECK;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 5'd1;
                    end
                end
                S_CHECK:
                begin
                    if (fit)
                    begin
                        out_data_reg <= d_val[OFFSET_W-1:0];
                        in_use_reg[slot_reg] <= 1'b1;
                        count_reg <= count_reg + CW'(1);
                        total_reg <= total_reg + ARENA_W'(size_reg);
                        if (prev_reg == NULL_SLOT)
                        begin
                            head_reg       <= NW'(slot_reg);
                            out_status_reg <= ST_OK;
                            out_valid_reg  <= 1'b1;
                            state_reg      <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_LINK;
                        end
                    end
                    else if (cur_null)
                    begin
                        out_data_reg   <= '0;
                        out_status_reg <= ST_NO_SPACE;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        base_reg     <= next_start;
                        prev_reg     <= cur_reg;
                        prev_hdr_reg <= rd_hdr;
                        prev_len_reg <= rd_len;
                        cur_reg      <= rd_link;
                        state_reg    <= S_FETCH;
                    end
                end
                S_LINK:
                begin
                    out_status_reg <= ST_OK;
                    out_valid_reg  <= 1'b1;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- sv/ffaa_checker.sv -----
// Port-level checks for first_fit_arena_allocator, bound into each instance of it.
// Depends on ffaa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ffaa_checker
    import ffaa_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("request taken while a result is pending");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[15:0] == 16'd0))
        else $error("failed request returned an offset");

    a_offset_floor: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[15:0] != 16'd0) |-> (m_tdata[15:0] >= 16'd16))
        else $error("data offset overlaps reserved word or header");

endmodule

bind first_fit_arena_allocator ffaa_checker u_ffaa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
